// ===== src/bounded_top_k_selector_assert.svh =====
// Assertion macros shared by the selector's checker.
`ifndef BOUNDED_TOP_K_SELECTOR_ASSERT_SVH
`define BOUNDED_TOP_K_SELECTOR_ASSERT_SVH

// Clocked assertion, held off while reset is active.
`define BTKS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define BTKS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/btks_pkg.sv =====
// Package: field widths, tdata layout and cell control type of the top-k selector.
`timescale 1ns / 1ps
`default_nettype none

package btks_pkg;

    localparam int KEY_W   = 63;
    localparam int TAG_W   = 32;
    localparam int RANK_W  = 6;
    localparam int COUNT_W = 7;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 7;

    // input tdata: new_key, entry_tag, rank, zero pad
    localparam int S_DATA_W = 104;
    // output tdata: kept, entry_count, out_valid, out_key, out_tag
    localparam int M_DATA_W = 104;

    // request kinds carried on tuser
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_READ   = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEEP_LARGEST    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY_IN_USE = 8'd1;

    typedef logic [KEY_W-1:0] key_t;
    typedef logic [TAG_W-1:0] tag_t;

    // control broadcast to every cell
    typedef struct packed {
        logic shift_en;      // insert accepted and entry taken
        logic keep_largest;  // ordering mode
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== src/bounded_top_k_selector.sv =====
// Top level of the bounded top-k selector: cell chain, count, config and output register.
`timescale 1ns / 1ps
`default_nettype none

// Keeps the best capacity_in_use entries (largest or smallest keys) of a stream
// in a chain of CAPACITY cells, sorted best first. Every cell compares the offered
// key against its own entry at once; an accepted insert shifts the entries below
// the insertion point one cell toward the end, so each request (insert or rank
// read) is resolved combinationally and the block takes one request per cycle
// while the output register can drain; the result is registered. A write to
// keep_largest empties the store; a write to capacity_in_use drops the entries
// beyond the new capacity. No clearing pass is needed after reset. The user must
// write configuration only while the block is idle; the block does not enforce it.
module bounded_top_k_selector #(
    parameter int CAPACITY = 64
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // s_tdata, low bit up: new_key[62:0], entry_tag[94:63], rank[100:95], zero pad
    input  wire logic [btks_pkg::S_DATA_W-1:0]    s_tdata,
    // s_tuser: func (0 insert, 1 read)
    input  wire logic                             s_tuser,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // m_tdata, low bit up: kept[0], entry_count[7:1], out_valid[8],
    // out_key[71:9], out_tag[103:72]
    output logic [btks_pkg::M_DATA_W-1:0]         m_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [btks_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [btks_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import btks_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int VW = (CW > CFG_DATA_W) ? CW : CFG_DATA_W;
    localparam int MW = (CW > RANK_W) ? CW : RANK_W;
    localparam int RESET_CAP = (CAPACITY < 64) ? CAPACITY : 64;

    // unpacked request
    key_t              in_key;
    tag_t              in_tag;
    logic [RANK_W-1:0] in_rank;
    assign in_key  = s_tdata[KEY_W-1:0];
    assign in_tag  = s_tdata[KEY_W+TAG_W-1:KEY_W];
    assign in_rank = s_tdata[KEY_W+TAG_W+RANK_W-1:KEY_W+TAG_W];

    logic accept;
    logic cfg_we;
    assign s_tready  = !m_tvalid || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid;

    // control state
    logic          keep_largest_reg, keep_largest_next;
    logic [CW-1:0] cap_reg, cap_next;
    logic [CW-1:0] held_reg, held_next;

    // chain wiring
    key_t                cell_key [CAPACITY];
    tag_t                cell_tag [CAPACITY];
    logic [CAPACITY-1:0] better;
    logic [CAPACITY-1:0] occupied;
    logic [CAPACITY-1:0] rd_sel;
    cell_ctrl_t          ctrl;

    logic          full;
    logic [IW-1:0] last_idx;
    logic          take;
    logic          is_insert;

    assign is_insert = (s_tuser == FUNC_INSERT);
    assign full      = (held_reg == cap_reg);
    assign last_idx  = IW'(held_reg - CW'(1));
    assign take      = !full || better[last_idx];

    assign ctrl.shift_en     = accept && is_insert && take;
    assign ctrl.keep_largest = keep_largest_reg;

    // row of cells, each but the head fed by its left neighbor
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        assign occupied[i] = (CW'(i) < held_reg);
        assign rd_sel[i]   = (MW'(in_rank) == MW'(i));
        if (i == 0)
        begin : g_head
            btks_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .occupied    (occupied[i]),
                .new_key     (in_key),
                .new_tag     (in_tag),
                .left_better (1'b0),
                .left_key    (in_key),
                .left_tag    (in_tag),
                .cell_key    (cell_key[i]),
                .cell_tag    (cell_tag[i]),
                .better      (better[i])
            );
        end
        else
        begin : g_body
            btks_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .occupied    (occupied[i]),
                .new_key     (in_key),
                .new_tag     (in_tag),
                .left_better (better[i-1]),
                .left_key    (cell_key[i-1]),
                .left_tag    (cell_tag[i-1]),
                .cell_key    (cell_key[i]),
                .cell_tag    (cell_tag[i]),
                .better      (better[i])
            );
        end
    end

    // one-hot rank select across the chain
    key_t rd_key;
    tag_t rd_tag;
    always_comb
    begin
        rd_key = '0;
        rd_tag = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (rd_sel[i])
            begin
                rd_key = rd_key | cell_key[i];
                rd_tag = rd_tag | cell_tag[i];
            end
        end
    end

    logic rd_hit;
    assign rd_hit = (MW'(in_rank) < MW'(held_reg));

    // effective capacity of a write: 0 acts as 1, clipped to the chain length
    logic [VW-1:0] cfg_cap_ext;
    logic [CW-1:0] cfg_cap_eff;
    assign cfg_cap_ext = VW'(cfg_data);
    always_comb
    begin
        if (cfg_cap_ext == '0)
        begin
            cfg_cap_eff = CW'(1);
        end
        else if (cfg_cap_ext > VW'(CAPACITY))
        begin
            cfg_cap_eff = CW'(CAPACITY);
        end
        else
        begin
            cfg_cap_eff = CW'(cfg_cap_ext);
        end
    end

    // configuration and count update
    always_comb
    begin
        keep_largest_next = keep_largest_reg;
        cap_next          = cap_reg;
        held_next         = held_reg;
        if (accept && is_insert && !full)
        begin
            held_next = held_reg + CW'(1);
        end
        if (cfg_we)
        begin
            case (cfg_index)
                REG_KEEP_LARGEST:
                begin
                    keep_largest_next = cfg_data[0];
                    held_next         = '0;
                end
                REG_CAPACITY_IN_USE:
                begin
                    cap_next = cfg_cap_eff;
                    if (held_reg > cfg_cap_eff)
                    begin
                        held_next = cfg_cap_eff;
                    end
                end
                default:
                begin
                    keep_largest_next = keep_largest_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_largest_reg <= 1'b0;
            cap_reg          <= CW'(RESET_CAP);
            held_reg         <= '0;
        end
        else
        begin
            keep_largest_reg <= keep_largest_next;
            cap_reg          <= cap_next;
            held_reg         <= held_next;
        end
    end

    // result register
    logic [M_DATA_W-1:0] out_data_reg, out_data_next;
    logic                out_valid_reg, out_valid_next;
    logic                res_kept;
    logic                res_valid;
    key_t                res_key;
    tag_t                res_tag;

    always_comb
    begin
        res_kept  = is_insert && take;
        res_valid = !is_insert && rd_hit;
        res_key   = res_valid ? rd_key : '0;
        res_tag   = res_valid ? rd_tag : '0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {res_tag, res_key, res_valid,
                              COUNT_W'(held_next), res_kept};
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ===== src/btks_cell.sv =====
// One cell of the sorted insertion chain: holds one ranked entry.
`timescale 1ns / 1ps
`default_nettype none

module btks_cell (
    input  wire logic                clk,
    input  wire btks_pkg::cell_ctrl_t ctrl,
    input  wire logic                occupied,    // this slot holds a live entry
    input  wire btks_pkg::key_t      new_key,
    input  wire btks_pkg::tag_t      new_tag,
    input  wire logic                left_better, // new entry goes at or left of neighbor
    input  wire btks_pkg::key_t      left_key,
    input  wire btks_pkg::tag_t      left_tag,
    output btks_pkg::key_t           cell_key,
    output btks_pkg::tag_t           cell_tag,
    output logic                     better       // new entry ranks above this slot
);
    import btks_pkg::*;

    key_t key_reg, key_next;
    tag_t tag_reg, tag_next;

    // strict compare: equal keys keep the earlier entry ahead
    always_comb
    begin
        if (!occupied)
        begin
            better = 1'b1;
        end
        else if (ctrl.keep_largest)
        begin
            better = (new_key > key_reg);
        end
        else
        begin
            better = (new_key < key_reg);
        end
    end

    // shift from left neighbor, take the new entry, or hold
    always_comb
    begin
        key_next = key_reg;
        tag_next = tag_reg;
        if (ctrl.shift_en)
        begin
            if (left_better)
            begin
                key_next = left_key;
                tag_next = left_tag;
            end
            else if (better)
            begin
                key_next = new_key;
                tag_next = new_tag;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        tag_reg <= tag_next;
    end

    assign cell_key = key_reg;
    assign cell_tag = tag_reg;

endmodule

`default_nettype wire

// ===== src/btks_checker.sv =====
// Port-level checker for the top-k selector, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "bounded_top_k_selector_assert.svh"

module btks_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic [btks_pkg::M_DATA_W-1:0] m_tdata,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready
);
    import btks_pkg::*;

    // a stalled result holds
    `BTKS_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

    // an insert result and a read hit never show together
    `BTKS_ASSERT(a_kind, m_tvalid |-> !(m_tdata[0] && m_tdata[8]), "kept and out_valid both set")

    // count never passes the largest capacity
    `BTKS_ASSERT(a_count, m_tvalid |-> (m_tdata[7:1] <= 7'd64), "entry_count out of range")

    // key and tag are zero unless the read hit
    `BTKS_ASSERT(a_zero, m_tvalid && !m_tdata[8] |-> (m_tdata[103:9] == '0), "payload not zero on miss")

    // an accepted request yields a result on the next cycle
    `BTKS_ASSERT(a_result, s_tvalid && s_tready |=> m_tvalid, "accepted request gave no result")

endmodule

bind bounded_top_k_selector btks_checker u_btks_checker (.*);

`default_nettype wire

// ===== tb/tb_bounded_top_k_selector.sv =====
// Self-checking testbench for the bounded top-k selector: directed table, then random phases.
`timescale 1ns / 1ps

module tb_bounded_top_k_selector;
    import btks_pkg::*;

    localparam int CAPACITY        = 64;
    localparam int NUM_PHASES      = 9;
    localparam int REQS_PER_PHASE  = 103;
    localparam int LONG_HOLD       = 250;
    localparam int MAX_PRINTED     = 40;

    // register indexes outside the map, expected to be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_IDX  = 8'hFF;

    localparam key_t KEY_MAX = {KEY_W{1'b1}};
    localparam tag_t TAG_MAX = {TAG_W{1'b1}};

    // result word, kept in bit 0
    typedef struct packed {
        tag_t               tag;
        key_t               key;
        logic               valid;
        logic [COUNT_W-1:0] count;
        logic               kept;
    } result_t;

    // one row of the stimulus plan: a register write or a request
    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] val;
        logic                  func;
        key_t                  key;
        tag_t                  tag;
        logic [RANK_W-1:0]     rank;
        bit                    fixed;
        result_t               want;
    } plan_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic [S_DATA_W-1:0]    s_tdata;
    logic                   s_tuser;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [M_DATA_W-1:0]    m_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // shadow copy of the ranked store
    key_t                   shadow_key [CAPACITY];
    tag_t                   shadow_tag [CAPACITY];
    int                     shadow_count;
    logic                   shadow_largest;
    logic [CFG_DATA_W-1:0]  shadow_cap;

    result_t                pending_results [$];
    plan_row_t              directed_plan [$];
    int                     mismatches = 0;
    bit                     src_idle_en = 1'b1;
    bit                     sink_idle_en = 1'b1;
    bit                     long_hold = 1'b0;
    result_t                mon_got;
    result_t                mon_want;

    bounded_top_k_selector uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // one line per mismatch, printing capped
    task automatic report_mismatch(input string field, input logic [127:0] got,
                                   input logic [127:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, field, got, want);
    endtask

    function automatic int active_capacity();
        int c;
        c = int'(shadow_cap);
        if (c < 1)
            c = 1;
        if (c > CAPACITY)
            c = CAPACITY;
        return c;
    endfunction

    function automatic bit outranks(key_t a, key_t b);
        return shadow_largest ? (a > b) : (a < b);
    endfunction

    // register write applied to the shadow state
    function automatic void shadow_write(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] val);
        if (idx == REG_KEEP_LARGEST)
        begin
            shadow_largest = val[0];
            shadow_count = 0;
        end
        else if (idx == REG_CAPACITY_IN_USE)
        begin
            shadow_cap = val;
            if (shadow_count > active_capacity())
                shadow_count = active_capacity();
        end
    endfunction

    // expected result of one request, updating the shadow store
    function automatic result_t rank_update(logic func, key_t key, tag_t tag,
                                            logic [RANK_W-1:0] rank);
        result_t r;
        int      last;
        int      pos;
        bit      take;
        r = '0;
        take = 1'b0;
        if (func == FUNC_INSERT)
        begin
            if (shadow_count < active_capacity())
            begin
                last = shadow_count;
                take = 1'b1;
                shadow_count++;
            end
            else
            begin
                // store full: displace the worst only on a strictly better key
                last = shadow_count - 1;
                take = outranks(key, shadow_key[last]);
            end
            if (take)
            begin
                // earlier arrivals stay ahead of equal keys
                pos = 0;
                while (pos < last && !outranks(key, shadow_key[pos]))
                    pos++;
                for (int i = last; i > pos; i--)
                begin
                    shadow_key[i] = shadow_key[i-1];
                    shadow_tag[i] = shadow_tag[i-1];
                end
                shadow_key[pos] = key;
                shadow_tag[pos] = tag;
            end
            r.kept = take;
        end
        else if (int'(rank) < shadow_count)
        begin
            r.valid = 1'b1;
            r.key = shadow_key[rank];
            r.tag = shadow_tag[rank];
        end
        r.count = shadow_count[COUNT_W-1:0];
        return r;
    endfunction

    // plan builders for the directed table
    task automatic plan_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        plan_row_t row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.idx = idx;
        row.val = val;
        directed_plan.push_back(row);
    endtask

    task automatic plan_req(input logic func, input key_t key, input tag_t tag,
                            input logic [RANK_W-1:0] rank);
        plan_row_t row;
        row = '{default: '0};
        row.func = func;
        row.key = key;
        row.tag = tag;
        row.rank = rank;
        directed_plan.push_back(row);
    endtask

    task automatic plan_fixed(input logic func, input key_t key, input tag_t tag,
                              input logic [RANK_W-1:0] rank, input logic kept,
                              input int count, input logic valid, input key_t okey,
                              input tag_t otag);
        plan_row_t row;
        row = '{default: '0};
        row.func = func;
        row.key = key;
        row.tag = tag;
        row.rank = rank;
        row.fixed = 1'b1;
        row.want.kept = kept;
        row.want.count = count[COUNT_W-1:0];
        row.want.valid = valid;
        row.want.key = okey;
        row.want.tag = otag;
        directed_plan.push_back(row);
    endtask

    // present one request, optionally after an idle burst with junk on the bus
    task automatic send_request(input plan_row_t row);
        logic [127:0] junk;
        result_t      predicted;
        if (src_idle_en && $urandom_range(0, 5) == 0)
        begin
            junk = {$urandom, $urandom, $urandom, $urandom};
            s_tvalid <= 1'b0;
            s_tuser <= junk[127];
            s_tdata <= junk[S_DATA_W-1:0];
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= row.func;
        s_tdata <= {3'b000, row.rank, row.tag, row.key};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = rank_update(row.func, row.key, row.tag, row.rank);
        pending_results.push_back(row.fixed ? row.want : predicted);
    endtask

    // stop requests, wait for all results, then let the pipeline settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        shadow_write(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // result sink: random stalls plus one long hold-off
    initial
    begin
        m_tready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (long_hold)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold = 1'b0;
            end
            else if (sink_idle_en && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            mon_got = result_t'(m_tdata);
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", 128'(m_tdata), '0);
            else
            begin
                mon_want = pending_results.pop_front();
                if (mon_got.kept !== mon_want.kept)
                    report_mismatch("kept", 128'(mon_got.kept), 128'(mon_want.kept));
                if (mon_got.count !== mon_want.count)
                    report_mismatch("entry_count", 128'(mon_got.count), 128'(mon_want.count));
                if (mon_got.valid !== mon_want.valid)
                    report_mismatch("out_valid", 128'(mon_got.valid), 128'(mon_want.valid));
                if (mon_got.key !== mon_want.key)
                    report_mismatch("out_key", 128'(mon_got.key), 128'(mon_want.key));
                if (mon_got.tag !== mon_want.tag)
                    report_mismatch("out_tag", 128'(mon_got.tag), 128'(mon_want.tag));
            end
        end
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("** bounded_top_k_selector: FAILED **");
        $finish;
    end

    // main sequence
    initial
    begin
        plan_row_t         row;
        logic [63:0]       wide;
        logic [6:0]        mode_val;
        int                ins_pct;
        int                waited;
        int                cap_val;

        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser <= FUNC_INSERT;
        s_tdata <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            shadow_key[i] = '0;
            shadow_tag[i] = '0;
        end
        shadow_count = 0;
        shadow_largest = 1'b0;
        shadow_cap = 7'd64;

        // directed table, starting in smallest mode with full capacity
        plan_fixed(FUNC_READ, '0, '0, 6'd0, 1'b0, 0, 1'b0, '0, '0);
        plan_fixed(FUNC_READ, KEY_MAX, TAG_MAX, 6'd63, 1'b0, 0, 1'b0, '0, '0);
        plan_fixed(FUNC_INSERT, KEY_MAX, TAG_MAX, 6'd0, 1'b1, 1, 1'b0, '0, '0);
        plan_fixed(FUNC_INSERT, '0, '0, 6'd63, 1'b1, 2, 1'b0, '0, '0);
        plan_req(FUNC_INSERT, 63'd5, 32'd1, 6'd0);
        plan_req(FUNC_INSERT, 63'd5, 32'd2, 6'd0);
        plan_fixed(FUNC_READ, '0, '0, 6'd0, 1'b0, 4, 1'b1, '0, '0);
        plan_req(FUNC_READ, '0, '0, 6'd1);
        plan_req(FUNC_READ, '0, '0, 6'd2);
        plan_fixed(FUNC_READ, '0, '0, 6'd3, 1'b0, 4, 1'b1, KEY_MAX, TAG_MAX);
        plan_fixed(FUNC_READ, '0, '0, 6'd4, 1'b0, 4, 1'b0, '0, '0);
        // lowering the capacity drops the worst entries
        plan_cfg(REG_CAPACITY_IN_USE, 7'd2);
        plan_req(FUNC_READ, '0, '0, 6'd1);
        plan_fixed(FUNC_READ, '0, '0, 6'd2, 1'b0, 2, 1'b0, '0, '0);
        // a key equal to the worst is not strictly better
        plan_fixed(FUNC_INSERT, 63'd5, 32'd3, 6'd0, 1'b0, 2, 1'b0, '0, '0);
        plan_fixed(FUNC_INSERT, 63'd9, 32'd3, 6'd0, 1'b0, 2, 1'b0, '0, '0);
        plan_req(FUNC_INSERT, 63'd1, 32'd4, 6'd0);
        // zero capacity behaves as one
        plan_cfg(REG_CAPACITY_IN_USE, 7'd0);
        plan_req(FUNC_READ, '0, '0, 6'd0);
        plan_fixed(FUNC_INSERT, KEY_MAX, 32'd5, 6'd0, 1'b0, 1, 1'b0, '0, '0);
        // oversized capacity clamps; mode write empties; unmapped writes ignored
        plan_cfg(REG_CAPACITY_IN_USE, 7'd127);
        plan_cfg(REG_KEEP_LARGEST, 7'b1010101);
        plan_cfg(REG_UNMAPPED, 7'd5);
        plan_cfg(REG_TOP_IDX, 7'd1);
        plan_fixed(FUNC_READ, '0, '0, 6'd0, 1'b0, 0, 1'b0, '0, '0);
        plan_fixed(FUNC_INSERT, 63'd7, 32'hA, 6'd0, 1'b1, 1, 1'b0, '0, '0);
        plan_req(FUNC_INSERT, KEY_MAX, 32'hB, 6'd0);
        plan_req(FUNC_INSERT, 63'd7, 32'hC, 6'd0);
        plan_fixed(FUNC_READ, '0, '0, 6'd0, 1'b0, 3, 1'b1, KEY_MAX, 32'hB);
        plan_req(FUNC_READ, '0, '0, 6'd2);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_plan[i])
        begin
            if (directed_plan[i].is_cfg)
            begin
                wait_idle();
                write_reg(directed_plan[i].idx, directed_plan[i].val);
            end
            else
                send_request(directed_plan[i]);
        end

        // random phases, each under its own setting
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            wait_idle();
            if (ph < 2 || $urandom_range(0, 1) == 1)
            begin
                mode_val = 7'($urandom);
                mode_val[0] = (ph == 0) ? 1'b1 : (ph == 1) ? 1'b0 : mode_val[0];
                write_reg(REG_KEEP_LARGEST, mode_val);
            end
            case (ph)
                0: cap_val = 64;
                1: cap_val = 1;
                2: cap_val = 0;
                3: cap_val = 127;
                default: cap_val = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 64)
                                                                : $urandom_range(1, 12);
            endcase
            write_reg(REG_CAPACITY_IN_USE, cap_val[CFG_DATA_W-1:0]);
            if (ph == 5)
                write_reg(REG_UNMAPPED, CFG_DATA_W'($urandom));
            if (ph == 3)
                long_hold = 1'b1;
            if (ph == NUM_PHASES - 1)
            begin
                src_idle_en = 1'b0;
                sink_idle_en = 1'b0;
            end
            ins_pct = (ph == 0) ? 85 : $urandom_range(40, 85);

            for (int n = 0; n < REQS_PER_PHASE; n++)
            begin
                row = '{default: '0};
                row.func = ($urandom_range(1, 100) <= ins_pct) ? FUNC_INSERT : FUNC_READ;
                // keys: extremes, a narrow range for ties, or anything
                wide = {$urandom, $urandom};
                case ($urandom_range(0, 9))
                    0: row.key = KEY_MAX;
                    1: row.key = '0;
                    2, 3, 4, 5: row.key = KEY_W'($urandom_range(0, 15));
                    default: row.key = wide[KEY_W-1:0];
                endcase
                row.tag = $urandom;
                if (shadow_count > 0 && $urandom_range(0, 4) != 0)
                    row.rank = RANK_W'($urandom_range(0, shadow_count - 1));
                else
                    row.rank = RANK_W'($urandom);
                send_request(row);
            end
        end

        // drain and finish
        s_tvalid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (5) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("missing results", 128'(pending_results.size()), '0);
        if (mismatches == 0)
            $display("** bounded_top_k_selector: PASSED **");
        else
            $display("** bounded_top_k_selector: FAILED **");
        $finish;
    end

endmodule
